[rtl/bounded_id_list_search_evict_assert.svh]
// Assertion macros for the bounded identifier list block
`ifndef BOUNDED_ID_LIST_SEARCH_EVICT_ASSERT_SVH
`define BOUNDED_ID_LIST_SEARCH_EVICT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define BLISE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define BLISE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BLISE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define BLISE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/blise_pkg.sv]
// Shared types and constants for the bounded identifier list
`default_nettype none

package blise_pkg;

  localparam int OP_W  = 3;
  localparam int CFG_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_FIND   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_STATS  = 3'd4
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic cfg_load;
    logic capture;
    logic exec;
  } blise_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } blise_stat_t;

endpackage

`default_nettype wire

[rtl/blise_ifs.sv]
// Channel interfaces: input items, result items and the configuration write
`default_nettype none

interface blise_in_if import blise_pkg::*; #(
  parameter int ID_W  = 32,
  parameter int POS_W = 4
) ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ID_W-1:0]   partner_id;
  logic [POS_W-1:0]  position;

  modport source (output valid, output operation, output partner_id, output position,
                  input ready);
  modport sink   (input valid, input operation, input partner_id, input position,
                  output ready);
endinterface

interface blise_out_if #(
  parameter int ID_W  = 32,
  parameter int POS_W = 4,
  parameter int CNT_W = 5
) ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [POS_W-1:0]  found_position;
  logic [ID_W-1:0]   entry_id;
  logic              entry_valid;
  logic [CNT_W-1:0]  used_count;
  logic [CNT_W-1:0]  max_used;
  logic              error;

  modport source (output valid, output found, output found_position, output entry_id,
                  output entry_valid, output used_count, output max_used, output error,
                  input ready);
  modport sink   (input valid, input found, input found_position, input entry_id,
                  input entry_valid, input used_count, input max_used, input error,
                  output ready);
endinterface

interface blise_cfg_if import blise_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_W-1:0]  mem_size;

  modport source (output valid, output mem_size, input ready);
  modport sink   (input valid, input mem_size, output ready);
endinterface

`default_nettype wire

[rtl/bounded_id_list_search_evict.sv]
// The accepting edge registers the compare of every cell; the execute state then shifts the
// cells and loads the result register. Items are taken one at a time: none is accepted while
// one executes, and a waiting result holds off the next item.
// A configuration write is always taken, loads the clipped size and empties the list.
// Reset (rst_n low, synchronous) clears size, count, peak and result valid;
// cell contents are not cleared and need no clearing pass.
`default_nettype none

`include "bounded_id_list_search_evict_assert.svh"

module bounded_id_list_search_evict import blise_pkg::*; #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  blise_in_if.sink    in_if,
  blise_out_if.source out_if,
  blise_cfg_if.sink   cfg_if
);

  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  blise_cmd_t  cmd;
  blise_stat_t stat;

  blise_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  blise_dp #(
    .DEPTH (DEPTH),
    .ID_W  (ID_BITS),
    .POS_W (POS_W),
    .CNT_W (CNT_W)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_mem_size  (cfg_if.mem_size),
    .in_operation  (in_if.operation),
    .in_partner_id (in_if.partner_id),
    .in_position   (in_if.position),
    .out_if        (out_if)
  );

  `BLISE_ASSERT_IMPLIES(a_found_below_count, clk, rst_n, out_if.valid && out_if.found, CNT_W'(out_if.found_position) < out_if.used_count, "match position not below used count")
  `BLISE_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready, "item accepted while the previous one executes")
  `BLISE_ASSERT_IMPLIES(a_read_valid_no_error, clk, rst_n, out_if.valid && out_if.entry_valid, !out_if.error && (out_if.used_count != '0), "valid read with error flag or empty list")

endmodule

`default_nettype wire

[rtl/blise_ctrl.sv]
// Controller: sequences capture and execute of one item at a time
`default_nettype none

module blise_ctrl import blise_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire blise_stat_t stat,
  output blise_cmd_t       cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // take an item only when the result register will be free for it
  assign in_ready  = (state_r == ST_IDLE) && stat.out_free;
  assign cfg_ready = 1'b1;

  always_comb begin
    cmd.cfg_load = cfg_valid;
    cmd.capture  = in_valid && in_ready;
    cmd.exec     = (state_r == ST_EXEC);
    state_nxt    = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/blise_dp.sv]
// Datapath: list cells, compare row, shift and result register
`default_nettype none

module blise_dp import blise_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int ID_W  = 32,
  parameter int POS_W = 4,
  parameter int CNT_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire blise_cmd_t        cmd,
  output blise_stat_t            stat,
  input  wire logic [CFG_W-1:0]  cfg_mem_size,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [ID_W-1:0]   in_partner_id,
  input  wire logic [POS_W-1:0]  in_position,
  blise_out_if.source            out_if
);

  localparam int CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  logic [ID_W-1:0]  entries_r [DEPTH];
  logic [DEPTH-1:0] match_r;
  op_t              op_r;
  logic [ID_W-1:0]  id_r;
  logic [POS_W-1:0] pos_r;
  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] used_r;
  logic [CNT_W-1:0] used_nxt;
  logic [CNT_W-1:0] peak_r;
  logic [CNT_W-1:0] peak_nxt;

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             found_r;
  logic [POS_W-1:0] found_pos_r;
  logic [ID_W-1:0]  entry_r;
  logic             entry_valid_r;
  logic             error_r;

  logic             res_found;
  logic [POS_W-1:0] res_found_pos;
  logic [ID_W-1:0]  res_entry;
  logic             res_entry_valid;
  logic             res_error;

  logic             shift_en;
  logic [POS_W-1:0] shift_from;
  logic             wr_en;
  logic [POS_W-1:0] wr_idx;
  logic [CNT_W-1:0] cap_new;
  logic [CMP_W-1:0] ms_ext;
  logic [CNT_W-1:0] pos_ext;

  // clip the written size to the number of cells
  assign ms_ext  = CMP_W'(cfg_mem_size);
  assign cap_new = (ms_ext < CMP_W'(DEPTH)) ? CNT_W'(ms_ext) : CNT_W'(DEPTH);
  assign pos_ext = CNT_W'(pos_r);

  assign stat.out_free = !out_valid_r || out_if.ready;

  always_comb begin
    shift_en        = 1'b0;
    shift_from      = '0;
    wr_en           = 1'b0;
    wr_idx          = '0;
    used_nxt        = used_r;
    peak_nxt        = peak_r;
    res_found       = 1'b0;
    res_found_pos   = '0;
    res_entry       = '0;
    res_entry_valid = 1'b0;
    res_error       = 1'b0;
    case (op_r)
      OP_ADD: begin
        if (cap_r != '0) begin
          wr_en = 1'b1;
          if (used_r >= cap_r) begin
            // evict the oldest: move all down, append at the top
            shift_en = 1'b1;
            wr_idx   = POS_W'(used_r - CNT_W'(1));
          end else begin
            wr_idx   = POS_W'(used_r);
            used_nxt = used_r + CNT_W'(1);
          end
          if (used_nxt > peak_r) begin
            peak_nxt = used_nxt;
          end
        end
      end
      OP_FIND: begin
        // lowest matching cell wins
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (match_r[i]) begin
            res_found     = 1'b1;
            res_found_pos = POS_W'(i);
          end
        end
      end
      OP_REMOVE: begin
        if (pos_ext < used_r) begin
          shift_en   = 1'b1;
          shift_from = pos_r;
          used_nxt   = used_r - CNT_W'(1);
        end else begin
          res_error = 1'b1;
        end
      end
      OP_READ: begin
        if (pos_ext < used_r) begin
          res_entry       = entries_r[pos_r];
          res_entry_valid = 1'b1;
        end else begin
          res_error = 1'b1;
        end
      end
      OP_STATS: begin
        peak_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g < DEPTH - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (cmd.exec) begin
          if (wr_en && (wr_idx == POS_W'(g))) begin
            entries_r[g] <= id_r;
          end else if (shift_en && (POS_W'(g) >= shift_from)) begin
            entries_r[g] <= entries_r[g+1];
          end
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (cmd.exec && wr_en && (wr_idx == POS_W'(g))) begin
          entries_r[g] <= id_r;
        end
      end
    end

    // compare stage: one cell against the incoming identifier
    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        match_r[g] <= (entries_r[g] == in_partner_id) && (CNT_W'(g) < used_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_t'(in_operation);
      id_r  <= in_partner_id;
      pos_r <= in_position;
    end
    if (cmd.exec) begin
      found_r       <= res_found;
      found_pos_r   <= res_found_pos;
      entry_r       <= res_entry;
      entry_valid_r <= res_entry_valid;
      error_r       <= res_error;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= '0;
      used_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.cfg_load) begin
        cap_r  <= cap_new;
        used_r <= '0;
      end else if (cmd.exec) begin
        used_r <= used_nxt;
        peak_r <= peak_nxt;
      end
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.found          = found_r;
  assign out_if.found_position = found_pos_r;
  assign out_if.entry_id       = entry_r;
  assign out_if.entry_valid    = entry_valid_r;
  assign out_if.used_count     = used_r;
  assign out_if.max_used       = peak_r;
  assign out_if.error          = error_r;

endmodule

`default_nettype wire

[verif/bounded_id_list_search_evict_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the bounded identifier list with search and eviction
module bounded_id_list_search_evict_test import blise_pkg::*; ();

  localparam int DEPTH        = 16;
  localparam int ID_BITS      = 32;
  localparam int POS_W        = 4;
  localparam int CNT_W        = 5;
  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 7;
  localparam int MAX_GAP      = 10;
  localparam int SETTLE       = 4;
  localparam int REPORT_LIMIT = 10;
  localparam int POOL_SIZE    = 8;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 130;

  localparam logic [OP_W-1:0]  OP_UNKNOWN_FIRST = OP_W'(OP_STATS + 1);
  localparam logic [OP_W-1:0]  OP_UNKNOWN_LAST  = '1;
  localparam logic [CFG_W-1:0] SIZE_MAX         = '1;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   found_position;
    logic [ID_BITS-1:0] entry_id;
    logic               entry_valid;
    logic [CNT_W-1:0]   used_count;
    logic [CNT_W-1:0]   max_used;
    logic               error;
  } list_result_t;

  logic clk;
  logic rst_n;

  blise_in_if  #(.ID_W(ID_BITS), .POS_W(POS_W))                in_ch ();
  blise_out_if #(.ID_W(ID_BITS), .POS_W(POS_W), .CNT_W(CNT_W)) out_ch ();
  blise_cfg_if                                                 cfg_ch ();

  bounded_id_list_search_evict #(.DEPTH(DEPTH), .ID_BITS(ID_BITS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // predictor copy of the list
  logic [ID_BITS-1:0] list_ids [DEPTH];
  int                 list_used;
  int                 list_peak;
  int                 list_size;

  list_result_t       predicted_results [$];
  logic [ID_BITS-1:0] id_pool [POOL_SIZE];
  int                 fail_count = 0;
  int                 report_count = 0;
  bit                 steady = 1'b0;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void clear_list();
    int i;
    for (i = 0; i < DEPTH; i++) list_ids[i] = '0;
    list_used = 0;
  endfunction

  // close the gap left by the entry at pos
  function automatic void drop_entry(int pos);
    int i;
    for (i = pos; i + 1 < list_used; i++) list_ids[i] = list_ids[i + 1];
    list_used--;
    list_ids[list_used] = '0;
  endfunction

  function automatic list_result_t apply_list_op(logic [OP_W-1:0] op,
                                                 logic [ID_BITS-1:0] id,
                                                 logic [POS_W-1:0] pos);
    list_result_t r;
    int cap;
    int i;
    r = '0;
    case (op)
      OP_ADD: begin
        cap = (list_size < DEPTH) ? list_size : DEPTH;
        if (cap != 0) begin
          if (list_used >= cap) drop_entry(0);
          if (list_used < DEPTH) begin
            list_ids[list_used] = id;
            list_used++;
          end
          if (list_used > list_peak) list_peak = list_used;
        end
      end
      OP_FIND: begin
        for (i = 0; i < list_used; i++) begin
          if (!r.found && list_ids[i] == id) begin
            r.found          = 1'b1;
            r.found_position = POS_W'(i);
          end
        end
      end
      OP_REMOVE: begin
        if (int'(pos) < list_used) drop_entry(int'(pos));
        else r.error = 1'b1;
      end
      OP_READ: begin
        if (int'(pos) < list_used) begin
          r.entry_id    = list_ids[pos];
          r.entry_valid = 1'b1;
        end else begin
          r.error = 1'b1;
        end
      end
      OP_STATS: list_peak = 0;
      default: ;
    endcase
    r.used_count = CNT_W'(list_used);
    r.max_used   = CNT_W'(list_peak);
    return r;
  endfunction

  function automatic void check_field(string name, logic [ID_BITS-1:0] want,
                                      logic [ID_BITS-1:0] got);
    if (want !== got) begin
      fail_count++;
      report_count++;
      if (report_count <= REPORT_LIMIT)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endfunction

  // compare each result item with the oldest prediction
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (predicted_results.size() == 0) begin
        fail_count++;
        report_count++;
        if (report_count <= REPORT_LIMIT)
          $display("result item with nothing pending: used_count %0d", out_ch.used_count);
      end else begin
        want = predicted_results.pop_front();
        check_field("found", ID_BITS'(want.found), ID_BITS'(out_ch.found));
        check_field("found_position", ID_BITS'(want.found_position),
                    ID_BITS'(out_ch.found_position));
        check_field("entry_id",       want.entry_id,       out_ch.entry_id);
        check_field("entry_valid", ID_BITS'(want.entry_valid), ID_BITS'(out_ch.entry_valid));
        check_field("used_count", ID_BITS'(want.used_count), ID_BITS'(out_ch.used_count));
        check_field("max_used", ID_BITS'(want.max_used), ID_BITS'(out_ch.max_used));
        check_field("error", ID_BITS'(want.error), ID_BITS'(out_ch.error));
      end
    end
  end

  // result side: outside steady phases, stall at random before taking each item
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready));
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_BITS-1:0] id,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.partner_id <= id;
    in_ch.position   <= pos;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready === 1'b1));
    predicted_results.push_back(apply_list_op(op, id, pos));
  endtask

  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_list_size(input logic [CFG_W-1:0] size);
    wait_until_drained();
    cfg_ch.valid    <= 1'b1;
    cfg_ch.mem_size <= size;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready === 1'b1));
    cfg_ch.valid <= 1'b0;
    list_size = int'(size);
    clear_list();
  endtask

  // zero capacity straight after reset: add must be ignored
  task automatic test_empty_list();
    send_item(OP_ADD, '1, '0);
    send_item(OP_FIND, '1, '0);
    send_item(OP_READ, '0, '0);
    send_item(OP_REMOVE, '0, '1);
    send_item(OP_STATS, '0, '0);
    send_item(OP_UNKNOWN_LAST, '1, '1);
  endtask

  task automatic test_eviction();
    write_list_size(CFG_W'(2));
    send_item(OP_ADD, '1, '0);
    send_item(OP_ADD, '0, '0);
    send_item(OP_ADD, 32'h8000_0001, '0);
    send_item(OP_READ, '0, 4'd0);
    send_item(OP_READ, '0, 4'd1);
    send_item(OP_FIND, '1, '0);
  endtask

  task automatic test_search_and_remove();
    write_list_size(CFG_W'(3));
    send_item(OP_ADD, 32'h5A5A_A5A5, '0);
    send_item(OP_ADD, 32'h0000_0001, '0);
    send_item(OP_ADD, 32'h5A5A_A5A5, '0);
    send_item(OP_FIND, 32'h5A5A_A5A5, '0);
    send_item(OP_FIND, 32'h0000_0001, '0);
    send_item(OP_REMOVE, '0, 4'd1);
    send_item(OP_READ, '0, 4'd1);
    send_item(OP_REMOVE, '0, 4'd2);
    send_item(OP_STATS, '0, '0);
    send_item(OP_READ, '0, '1);
    send_item(OP_UNKNOWN_FIRST, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] fixed_sizes [6];
    logic [CFG_W-1:0] size;
    logic [OP_W-1:0]  op;
    logic [ID_BITS-1:0] id;
    logic [POS_W-1:0] pos;
    int phase;
    int n;
    int count;
    int pick;
    fixed_sizes = '{CFG_W'(DEPTH), SIZE_MAX, CFG_W'(1), CFG_W'(0), CFG_W'(8),
                    CFG_W'(DEPTH + 1)};
    for (phase = 0; phase < PHASES; phase++) begin
      size = (phase < 6) ? fixed_sizes[phase] : CFG_W'($urandom_range(0, SIZE_MAX));
      write_list_size(size);
      steady = (phase % 3 == 1);
      // two extreme identifiers, the rest fresh each phase so that finds hit
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (n = 2; n < POOL_SIZE; n++) id_pool[n] = $urandom();
      count = (size == 0) ? PHASE_ITEMS / 4 : PHASE_ITEMS;
      for (n = 0; n < count; n++) begin
        // hold the sender until the block has emptied
        if (n == count / 2) wait_until_drained();
        pick = $urandom_range(0, 99);
        if (pick < 35)      op = OP_ADD;
        else if (pick < 60) op = OP_FIND;
        else if (pick < 75) op = OP_REMOVE;
        else if (pick < 93) op = OP_READ;
        else if (pick < 97) op = OP_STATS;
        else                op = OP_W'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
        id = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                        : $urandom();
        if (list_used > 0 && $urandom_range(0, 3) != 0)
          pos = POS_W'($urandom_range(0, list_used - 1));
        else
          pos = POS_W'($urandom_range(0, DEPTH - 1));
        send_item(op, id, pos);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_ADD;
    in_ch.partner_id <= '0;
    in_ch.position   <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.mem_size  <= '0;
    clear_list();
    list_peak = 0;
    list_size = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_eviction();
    test_search_and_remove();
    test_random_traffic();
    wait_until_drained();
    if (fail_count == 0) begin
      $display("bounded_id_list_search_evict_test: clean");
    end else begin
      $display("bounded_id_list_search_evict_test: errors");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("bounded_id_list_search_evict_test: errors");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/blise_pkg.sv
rtl/blise_ifs.sv
rtl/blise_ctrl.sv
rtl/blise_dp.sv
rtl/bounded_id_list_search_evict.sv
verif/bounded_id_list_search_evict_test.sv
